// ===== hw/rtl/si2dec_pkg.sv =====
// ----------------------------------------------------------------------------
// si2dec_pkg
// Shared types, constants and the binary-to-BCD step function of the signed
// integer to decimal text converter.
// ----------------------------------------------------------------------------
package si2dec_pkg;

   localparam int ValueW        = 32;
   localparam int DigitsMax     = 10;
   localparam int BcdW          = 4 * DigitsMax;
   localparam int DdStages      = 4;
   localparam int StepsPerStage = ValueW / DdStages;
   localparam int CharW         = 8;

   localparam logic [CharW-1:0] AsciiZero  = 8'd48;
   localparam logic [CharW-1:0] AsciiMinus = 8'd45;

   typedef logic [BcdW-1:0]   bcd_type;
   typedef logic [ValueW-1:0] bin_type;

   typedef struct packed {
      bcd_type bcd;
      bin_type bin;
   } dd_type;

   function automatic dd_type dd_steps(dd_type cur);
      dd_type     acc;
      logic [3:0] dig;
      acc = cur;
      for (int s = 0; s < StepsPerStage; s++) begin
         for (int d = 0; d < DigitsMax; d++) begin
            dig = acc.bcd[d*4 +: 4];
            if (dig >= 4'd5) begin
               acc.bcd[d*4 +: 4] = dig + 4'd3;
            end
         end
         {acc.bcd, acc.bin} = {acc.bcd[BcdW-2:0], acc.bin, 1'b0};
      end
      return acc;
   endfunction

endpackage

// ===== hw/rtl/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output beat, minus sign first, no leading zeros, last character flagged.
// ----------------------------------------------------------------------------
// Path: the input is registered in stage 0, passes conversion stages 1 to 4
// and is loaded into the output serializer, which presents the first character.
// Flow: a number of N characters (1..11) holds the serializer until all N are sent;
// the 5-stage pipeline buffers up to five beats meanwhile, then holds off input.
// Reset clears all valid bits; no clearing pass.
module signed_int_to_decimal_ascii_core
   import si2dec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic signed [31:0]   req_tdata,   // [31:0] value
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CharW-1:0]     rsp_tdata,   // [7:0] char_code
   output logic                 rsp_tlast    // last_char
);

   logic [DdStages:0] stg_valid_ff;
   logic [DdStages:0] stg_valid_in;
   logic [DdStages:0] stg_adv;
   logic [DdStages:0] stg_neg_ff;
   bin_type           stg_bin_ff [0:DdStages];
   bcd_type           stg_bcd_ff [1:DdStages];
   dd_type            stg_dd_in  [1:DdStages];

   logic              sr_valid_ff, sr_valid_in;
   logic              sr_neg_ff, sr_neg_in;
   bcd_type           sr_bcd_ff, sr_bcd_in;
   logic [3:0]        sr_left_ff, sr_left_in;
   logic              sr_free;
   logic              sr_load;
   logic              rsp_beat;

   logic [3:0]        top_dig;
   logic [3:0]        lead_zeros;
   bcd_type           ld_bcd;

   // ready chain
   always_comb begin
      stg_adv[DdStages] = !stg_valid_ff[DdStages] || sr_free;
      for (int k = DdStages - 1; k >= 0; k--) begin
         stg_adv[k] = !stg_valid_ff[k] || stg_adv[k+1];
      end
   end

   assign req_tready = stg_adv[0];

   always_comb begin
      stg_valid_in[0] = req_tvalid;
      for (int k = 1; k <= DdStages; k++) begin
         stg_valid_in[k] = stg_valid_ff[k-1];
      end
      stg_dd_in[1] = dd_steps('{bcd: '0, bin: stg_bin_ff[0]});
      for (int k = 2; k <= DdStages; k++) begin
         stg_dd_in[k] = dd_steps('{bcd: stg_bcd_ff[k-1], bin: stg_bin_ff[k-1]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         for (int k = 0; k <= DdStages; k++) begin
            if (stg_adv[k]) begin
               stg_valid_ff[k] <= stg_valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_adv[0]) begin
         stg_neg_ff[0] <= req_tdata[ValueW-1];
         stg_bin_ff[0] <= req_tdata[ValueW-1] ? bin_type'(-req_tdata) : bin_type'(req_tdata);
      end
      for (int k = 1; k <= DdStages; k++) begin
         if (stg_adv[k]) begin
            stg_neg_ff[k] <= stg_neg_ff[k-1];
            stg_bcd_ff[k] <= stg_dd_in[k].bcd;
            stg_bin_ff[k] <= stg_dd_in[k].bin;
         end
      end
   end

   // find the most significant nonzero digit and left-align the digits
   always_comb begin
      top_dig = '0;
      for (int d = 0; d < DigitsMax; d++) begin
         if (stg_bcd_ff[DdStages][d*4 +: 4] != 4'd0) begin
            top_dig = 4'(d);
         end
      end
      lead_zeros = 4'(DigitsMax - 1) - top_dig;
      ld_bcd     = stg_bcd_ff[DdStages] << {lead_zeros, 2'b00};
   end

   // output serializer
   assign rsp_tvalid = sr_valid_ff;
   assign rsp_tlast  = !sr_neg_ff && (sr_left_ff == 4'd1);
   assign rsp_tdata  = sr_neg_ff ? AsciiMinus
                                 : (AsciiZero | {4'd0, sr_bcd_ff[BcdW-1 -: 4]});
   assign rsp_beat   = sr_valid_ff && rsp_tready;
   assign sr_free    = !sr_valid_ff || (rsp_tready && rsp_tlast);
   assign sr_load    = sr_free && stg_valid_ff[DdStages];

   always_comb begin
      sr_valid_in = sr_valid_ff;
      sr_neg_in   = sr_neg_ff;
      sr_bcd_in   = sr_bcd_ff;
      sr_left_in  = sr_left_ff;
      if (sr_load) begin
         sr_valid_in = 1'b1;
         sr_neg_in   = stg_neg_ff[DdStages];
         sr_bcd_in   = ld_bcd;
         sr_left_in  = top_dig + 4'd1;
      end else if (rsp_beat) begin
         if (rsp_tlast) begin
            sr_valid_in = 1'b0;
         end else if (sr_neg_ff) begin
            sr_neg_in = 1'b0;
         end else begin
            sr_bcd_in  = {sr_bcd_ff[BcdW-5:0], 4'd0};
            sr_left_in = sr_left_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_valid_ff <= 1'b0;
      end else begin
         sr_valid_ff <= sr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_neg_ff  <= sr_neg_in;
      sr_bcd_ff  <= sr_bcd_in;
      sr_left_ff <= sr_left_in;
   end

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == AsciiMinus) ||
                     ((rsp_tdata >= AsciiZero) && (rsp_tdata <= AsciiZero + 8'd9)))
      else $error("output character outside minus and digits");

   a_left_count: assert property (@(posedge clock) disable iff (reset)
      sr_valid_ff |-> (sr_left_ff != 4'd0) && (sr_left_ff <= 4'(DigitsMax)))
      else $error("serializer digit count out of range");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff[DdStages] && !sr_free) |=>
         (stg_valid_ff[DdStages] && $stable(stg_bcd_ff[DdStages])))
      else $error("last conversion stage dropped a stalled item");

   a_last_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_tlast && !stg_valid_ff[DdStages]) |=> !sr_valid_ff)
      else $error("serializer kept a finished number");

endmodule
